[hdl/i2cms_pkg.sv]
// shared types, codes and defaults for the i2c master transaction sequencer
package i2cms_pkg;

  localparam int BUFFER_DEPTH_DEFAULT = 32;

  // input field widths
  localparam int KIND_W   = 3;
  localparam int ADDR_W   = 7;
  localparam int COUNT_W  = 6;
  localparam int SLOT_W   = 5;
  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 3;
  localparam int RCOUNT_W = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD     = 3'd0,
    KIND_START_WR = 3'd1,
    KIND_START_RD = 3'd2,
    KIND_STATUS   = 3'd3,
    KIND_READBACK = 3'd4
  } kind_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE        = 3'd0,
    CMD_START       = 3'd1,
    CMD_START_QUIET = 3'd2,
    CMD_STOP        = 3'd3,
    CMD_ACK         = 3'd4,
    CMD_NACK        = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_READY = 2'd0,
    MODE_TX    = 2'd1,
    MODE_RX    = 2'd2
  } mode_t;

  // two-wire engine status codes, prescaler bits cleared
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_REP_START   = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

endpackage

[hdl/i2cms_ram.sv]
// generic single-write, single-read ram with registered read data
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/i2c_master_transaction_sequencer.sv]
// Sequences i2c master write and read transfers on top of a byte-level bus engine.
// One beat in, one beat out: the block takes a new item every clock unless the result
// beat is stalled; each item passes an input register, then a result register, and
// the registered read port of the byte buffer ram, which supplies transmit bytes and
// read-back data, lines up with the result register. The buffer holds BUFFER_DEPTH
// bytes and has no clearing pass: read back only slots that were loaded or received.
module i2c_master_transaction_sequencer #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_address[6:0], byte_count[12:7], stop_at_end[13], buffer_slot[18:14],
  // data_byte[26:19], bus_status[34:27], bus_byte[42:35], zero[47:43]
  input  logic [47:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bus_command[2:0], drive_valid[3], drive_byte[11:4], transfer_done[12],
  // transfer_failed[13], busy_res[14], read_data[22:15], received_count[28:23],
  // zero[31:29]
  output logic [31:0] out_tdata
);

  import i2cms_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;

  // input register
  logic              s1_valid_r;
  logic [42:0]       s1_data_r;
  logic [KIND_W-1:0] s1_kind_r;

  // result register
  logic              s2_valid_r;
  cmd_t              s2_cmd_r;
  logic              s2_dv_r;
  logic [BYTE_W-1:0] s2_db_r;
  logic              s2_db_ram_r;
  logic              s2_done_r;
  logic              s2_fail_r;
  logic              s2_busy_r;
  logic              s2_rd_ram_r;
  logic [RCOUNT_W-1:0] s2_rcount_r;

  // sequencer state
  mode_t             mode_r, mode_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     limit_r, limit_nxt;
  logic [BYTE_W-1:0] addr_byte_r, addr_byte_nxt;
  logic              stop_wanted_r, stop_wanted_nxt;
  logic              restart_r, restart_nxt;

  // result fields computed from the input register
  cmd_t              cmd_nxt;
  logic              dv_nxt;
  logic [BYTE_W-1:0] db_nxt;
  logic              db_ram_nxt;
  logic              done_nxt;
  logic              fail_nxt;
  logic              rd_ram_nxt;

  logic              s1_adv;
  logic [BYTE_W-1:0] ram_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;

  // fields of the registered beat
  kind_t              kind;
  logic [ADDR_W-1:0]  f_addr;
  logic [COUNT_W-1:0] f_count;
  logic               f_stop;
  logic [SLOT_W-1:0]  f_slot;
  logic [BYTE_W-1:0]  f_data;
  logic [BYTE_W-1:0]  st_code;
  logic [BYTE_W-1:0]  f_rx;

  logic              is_start;
  logic              start_rd;
  logic              start_reject;
  logic [BYTE_W-1:0] new_addr_byte;
  logic              slot_ok;
  logic              pos_in_buf;
  logic              tx_more;
  logic              rx_store;
  logic [CW-1:0]     pos_after_rx;

  assign kind    = kind_t'(s1_kind_r);
  assign f_addr  = s1_data_r[6:0];
  assign f_count = s1_data_r[12:7];
  assign f_stop  = s1_data_r[13];
  assign f_slot  = s1_data_r[18:14];
  assign f_data  = s1_data_r[26:19];
  assign st_code = {s1_data_r[34:30], 3'b000};
  assign f_rx    = s1_data_r[42:35];

  assign s1_adv    = s1_valid_r && (!s2_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign is_start      = (kind == KIND_START_WR) || (kind == KIND_START_RD);
  assign start_rd      = (kind == KIND_START_RD);
  assign start_reject  = (mode_r != MODE_READY) || (32'(f_count) > BUFFER_DEPTH) ||
                         (start_rd && (f_count == '0));
  assign new_addr_byte = {f_addr, start_rd};
  assign slot_ok       = 32'(f_slot) < BUFFER_DEPTH;
  assign pos_in_buf    = 32'(pos_r) < BUFFER_DEPTH;
  assign tx_more       = (pos_r < limit_r) && pos_in_buf;
  assign rx_store      = (kind == KIND_STATUS) && (mode_r == MODE_RX) && pos_in_buf &&
                         ((st_code == ST_DATA_R_ACK) || (st_code == ST_DATA_R_NACK));
  assign pos_after_rx  = rx_store ? pos_r + CW'(1) : pos_r;

  // buffer ram: loads and received bytes write, transmit and read-back read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(pos_r);
    ram_wdata = f_rx;
    if (s1_adv) begin
      if ((kind == KIND_LOAD) && (mode_r == MODE_READY) && slot_ok) begin
        ram_we    = 1'b1;
        ram_waddr = AW'(f_slot);
        ram_wdata = f_data;
      end else if (rx_store) begin
        ram_we = 1'b1;
      end
    end
  end

  assign ram_raddr = (kind == KIND_READBACK) ? AW'(f_slot) : AW'(pos_r);

  i2cms_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s1_adv),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // next state
  always_comb begin
    mode_nxt        = mode_r;
    pos_nxt         = pos_r;
    limit_nxt       = limit_r;
    addr_byte_nxt   = addr_byte_r;
    stop_wanted_nxt = stop_wanted_r;
    restart_nxt     = restart_r;
    unique case (kind)
      KIND_START_WR, KIND_START_RD: begin
        if (!start_reject) begin
          mode_nxt        = start_rd ? MODE_RX : MODE_TX;
          stop_wanted_nxt = f_stop;
          pos_nxt         = '0;
          limit_nxt       = start_rd ? CW'(f_count) - CW'(1) : CW'(f_count);
          addr_byte_nxt   = new_addr_byte;
          restart_nxt     = 1'b0;
        end
      end
      KIND_STATUS: begin
        pos_nxt = pos_after_rx;
        if (mode_r != MODE_READY) begin
          unique case (st_code)
            ST_BUS_ERROR, ST_ARB_LOST: mode_nxt = MODE_READY;
            ST_SLA_W_ACK, ST_DATA_W_ACK: begin
              if (mode_r == MODE_TX) begin
                if (tx_more) begin
                  pos_nxt = pos_r + CW'(1);
                end else begin
                  mode_nxt    = MODE_READY;
                  restart_nxt = restart_r || !stop_wanted_r;
                end
              end
            end
            ST_SLA_W_NACK, ST_DATA_W_NACK: begin
              if (mode_r == MODE_TX) begin
                mode_nxt = MODE_READY;
              end
            end
            ST_DATA_R_NACK: begin
              if (mode_r == MODE_RX) begin
                mode_nxt    = MODE_READY;
                restart_nxt = restart_r || !stop_wanted_r;
              end
            end
            ST_SLA_R_NACK: begin
              if (mode_r == MODE_RX) begin
                mode_nxt = MODE_READY;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    cmd_nxt    = CMD_NONE;
    dv_nxt     = 1'b0;
    db_nxt     = '0;
    db_ram_nxt = 1'b0;
    done_nxt   = 1'b0;
    fail_nxt   = 1'b0;
    rd_ram_nxt = 1'b0;
    unique case (kind)
      KIND_START_WR, KIND_START_RD: begin
        if (start_reject) begin
          done_nxt = 1'b1;
          fail_nxt = 1'b1;
        end else if (restart_r) begin
          dv_nxt  = 1'b1;
          db_nxt  = new_addr_byte;
          cmd_nxt = CMD_ACK;
        end else begin
          cmd_nxt = CMD_START;
        end
      end
      KIND_STATUS: begin
        if (st_code == ST_BUS_ERROR) begin
          cmd_nxt = CMD_STOP;
          if (mode_r != MODE_READY) begin
            done_nxt = 1'b1;
            fail_nxt = 1'b1;
          end
        end else if (mode_r != MODE_READY) begin
          unique case (st_code)
            ST_START, ST_REP_START: begin
              dv_nxt  = 1'b1;
              db_nxt  = addr_byte_r;
              cmd_nxt = CMD_ACK;
            end
            ST_ARB_LOST: begin
              done_nxt = 1'b1;
              fail_nxt = 1'b1;
              cmd_nxt  = CMD_ACK;
            end
            ST_SLA_W_ACK, ST_DATA_W_ACK: begin
              if (mode_r == MODE_TX) begin
                if (tx_more) begin
                  dv_nxt     = 1'b1;
                  db_ram_nxt = 1'b1;
                  cmd_nxt    = CMD_ACK;
                end else begin
                  done_nxt = 1'b1;
                  cmd_nxt  = stop_wanted_r ? CMD_STOP : CMD_START_QUIET;
                end
              end
            end
            ST_SLA_W_NACK, ST_DATA_W_NACK: begin
              if (mode_r == MODE_TX) begin
                done_nxt = 1'b1;
                fail_nxt = 1'b1;
                cmd_nxt  = CMD_STOP;
              end
            end
            ST_SLA_R_ACK, ST_DATA_R_ACK: begin
              if (mode_r == MODE_RX) begin
                cmd_nxt = (pos_after_rx < limit_r) ? CMD_ACK : CMD_NACK;
              end
            end
            ST_DATA_R_NACK: begin
              if (mode_r == MODE_RX) begin
                done_nxt = 1'b1;
                cmd_nxt  = stop_wanted_r ? CMD_STOP : CMD_START_QUIET;
              end
            end
            ST_SLA_R_NACK: begin
              if (mode_r == MODE_RX) begin
                done_nxt = 1'b1;
                fail_nxt = 1'b1;
                cmd_nxt  = CMD_STOP;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_READBACK: rd_ram_nxt = slot_ok;
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      mode_r        <= MODE_READY;
      pos_r         <= '0;
      limit_r       <= '0;
      addr_byte_r   <= '0;
      stop_wanted_r <= 1'b0;
      restart_r     <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        s2_valid_r    <= 1'b1;
        mode_r        <= mode_nxt;
        pos_r         <= pos_nxt;
        limit_r       <= limit_nxt;
        addr_byte_r   <= addr_byte_nxt;
        stop_wanted_r <= stop_wanted_nxt;
        restart_r     <= restart_nxt;
      end else if (out_tready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[42:0];
      s1_kind_r <= in_tuser;
    end
    if (s1_adv) begin
      s2_cmd_r    <= cmd_nxt;
      s2_dv_r     <= dv_nxt;
      s2_db_r     <= db_nxt;
      s2_db_ram_r <= db_ram_nxt;
      s2_done_r   <= done_nxt;
      s2_fail_r   <= fail_nxt;
      s2_busy_r   <= (mode_nxt != MODE_READY);
      s2_rd_ram_r <= rd_ram_nxt;
      s2_rcount_r <= pos_nxt[RCOUNT_W-1:0];
    end
  end

  // ram read data joins the result beat here; it holds while the beat is stalled
  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {3'b000,
                       s2_rcount_r,
                       s2_rd_ram_r ? ram_q : 8'h00,
                       s2_busy_r,
                       s2_fail_r,
                       s2_done_r,
                       s2_db_ram_r ? ram_q : s2_db_r,
                       s2_dv_r,
                       s2_cmd_r};

  a_drive_with_ack: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_dv_r |-> s2_cmd_r == CMD_ACK)
    else $error("drive byte without continue command");

  a_fail_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_fail_r |-> s2_done_r)
    else $error("failure flagged without completion");

  a_ram_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_tready |=> ram_q === $past(ram_q))
    else $error("buffer read data changed under a stalled beat");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) <= BUFFER_DEPTH)
    else $error("buffer position beyond depth");

  a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    restart_r |-> mode_r == MODE_READY)
    else $error("repeated start armed during a transfer");

endmodule

[dv/i2cms_response_checker.sv]
// response checker for the i2c master transaction sequencer: predicts each result beat and compares
module i2cms_response_checker
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // target_address[6:0], byte_count[12:7], stop_at_end[13], buffer_slot[18:14],
  // data_byte[26:19], bus_status[34:27], bus_byte[42:35], zero[47:43]
  input  logic [47:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // bus_command[2:0], drive_valid[3], drive_byte[11:4], transfer_done[12],
  // transfer_failed[13], busy_res[14], read_data[22:15], received_count[28:23],
  // zero[31:29]
  input  logic [31:0] out_tdata,
  output int          mismatch_count,
  output int          pending_count,
  output int          checked_count
);

  localparam int STORE_DEPTH = BUFFER_DEPTH_DEFAULT;

  // first member sits in the top bits
  typedef struct packed {
    logic [2:0] pad;
    logic [5:0] received_count;
    logic [7:0] read_data;
    logic       busy;
    logic       failed;
    logic       done;
    logic [7:0] drive_byte;
    logic       drive_valid;
    cmd_t       cmd;
  } response_t;

  logic [7:0] byte_mem [STORE_DEPTH];
  logic [5:0] xfer_pos;
  logic [5:0] xfer_limit;
  logic [7:0] addr_byte;
  mode_t      xfer_mode;
  logic       stop_flag;
  logic       restart_flag;

  response_t  pending_responses[$];
  int         errors = 0;
  int         checked = 0;

  function automatic void end_transfer(input logic failed, input cmd_t cmd, inout response_t r);
    xfer_mode = MODE_READY;
    r.done    = 1'b1;
    r.failed  = failed;
    r.cmd     = cmd;
  endfunction

  function automatic void end_transfer_ok(inout response_t r);
    if (stop_flag) begin
      end_transfer(1'b0, CMD_STOP, r);
    end else begin
      restart_flag = 1'b1;
      end_transfer(1'b0, CMD_START_QUIET, r);
    end
  endfunction

  // position saturates at the buffer end, extra bytes are dropped
  function automatic void keep_received(input logic [7:0] b);
    if (xfer_pos < STORE_DEPTH) begin
      byte_mem[xfer_pos] = b;
      xfer_pos = xfer_pos + 6'd1;
    end
  endfunction

  function automatic response_t predict_response(input logic [2:0] kind, input logic [47:0] d);
    response_t  r;
    logic [6:0] addr;
    logic [5:0] count;
    logic       stop;
    logic [4:0] slot;
    logic [7:0] data;
    logic [7:0] st;
    logic [7:0] rx;
    logic       rd;
    r     = '0;
    addr  = d[6:0];
    count = d[12:7];
    stop  = d[13];
    slot  = d[18:14];
    data  = d[26:19];
    st    = d[34:27] & 8'hf8;
    rx    = d[42:35];
    rd    = (kind == KIND_START_RD);
    case (kind)
      KIND_LOAD: begin
        if (xfer_mode == MODE_READY) byte_mem[slot] = data;
      end
      KIND_START_WR, KIND_START_RD: begin
        if (xfer_mode != MODE_READY || count > STORE_DEPTH || (rd && count == 6'd0)) begin
          r.done   = 1'b1;
          r.failed = 1'b1;
        end else begin
          xfer_mode  = rd ? MODE_RX : MODE_TX;
          stop_flag  = stop;
          xfer_pos   = 6'd0;
          xfer_limit = rd ? count - 6'd1 : count;
          addr_byte  = {addr, rd};
          if (restart_flag) begin
            // repeated start already on the bus: address goes out directly
            restart_flag  = 1'b0;
            r.drive_valid = 1'b1;
            r.drive_byte  = addr_byte;
            r.cmd         = CMD_ACK;
          end else begin
            r.cmd = CMD_START;
          end
        end
      end
      KIND_STATUS: begin
        if (st == ST_BUS_ERROR) begin
          if (xfer_mode != MODE_READY) end_transfer(1'b1, CMD_STOP, r);
          else r.cmd = CMD_STOP;
        end else if (xfer_mode != MODE_READY) begin
          case (st)
            ST_START, ST_REP_START: begin
              r.drive_valid = 1'b1;
              r.drive_byte  = addr_byte;
              r.cmd         = CMD_ACK;
            end
            ST_ARB_LOST: end_transfer(1'b1, CMD_ACK, r);
            ST_SLA_W_ACK, ST_DATA_W_ACK: begin
              if (xfer_mode == MODE_TX) begin
                if (xfer_pos < xfer_limit && xfer_pos < STORE_DEPTH) begin
                  r.drive_valid = 1'b1;
                  r.drive_byte  = byte_mem[xfer_pos];
                  r.cmd         = CMD_ACK;
                  xfer_pos      = xfer_pos + 6'd1;
                end else begin
                  end_transfer_ok(r);
                end
              end
            end
            ST_SLA_W_NACK, ST_DATA_W_NACK: begin
              if (xfer_mode == MODE_TX) end_transfer(1'b1, CMD_STOP, r);
            end
            ST_SLA_R_ACK, ST_DATA_R_ACK: begin
              if (xfer_mode == MODE_RX) begin
                if (st == ST_DATA_R_ACK) keep_received(rx);
                r.cmd = (xfer_pos < xfer_limit) ? CMD_ACK : CMD_NACK;
              end
            end
            ST_DATA_R_NACK: begin
              if (xfer_mode == MODE_RX) begin
                keep_received(rx);
                end_transfer_ok(r);
              end
            end
            ST_SLA_R_NACK: begin
              if (xfer_mode == MODE_RX) end_transfer(1'b1, CMD_STOP, r);
            end
            default: ;
          endcase
        end
      end
      KIND_READBACK: r.read_data = byte_mem[slot];
      default: ;
    endcase
    r.busy           = (xfer_mode != MODE_READY);
    r.received_count = xfer_pos;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    response_t want;
    response_t got;
    if (!rst_n) begin
      xfer_pos     = 6'd0;
      xfer_limit   = 6'd0;
      addr_byte    = 8'd0;
      xfer_mode    = MODE_READY;
      stop_flag    = 1'b0;
      restart_flag = 1'b0;
      pending_responses.delete();
    end else begin
      // results lag their items, so retire before taking the new beat
      if (out_tvalid && out_tready) begin
        got = response_t'(out_tdata);
        if (pending_responses.size() == 0) begin
          $error("result beat %h with no item waiting", out_tdata);
          errors++;
        end else begin
          want = pending_responses.pop_front();
          compare_field("bus_command", want.cmd, got.cmd);
          compare_field("drive_valid", want.drive_valid, got.drive_valid);
          compare_field("drive_byte", want.drive_byte, got.drive_byte);
          compare_field("transfer_done", want.done, got.done);
          compare_field("transfer_failed", want.failed, got.failed);
          compare_field("busy_res", want.busy, got.busy);
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("received_count", want.received_count, got.received_count);
          compare_field("padding", want.pad, got.pad);
          checked++;
        end
      end
      if (in_tvalid && in_tready) pending_responses.push_back(predict_response(in_tuser, in_tdata));
    end
    mismatch_count <= errors;
    pending_count  <= pending_responses.size();
    checked_count  <= checked;
  end

endmodule

[dv/testbench.sv]
// top of the sequencer testbench: clock, reset, stimulus, receiver back-pressure and verdict
module testbench;
  import i2cms_pkg::*;

  localparam int ITEMS_TARGET    = 800;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  int mismatch_count;
  int pending_count;
  int checked_count;

  int cycle_count    = 0;
  int burst_left     = 8;
  int gap_len        = 0;
  int items_sent     = 0;
  int writes_started = 0;
  int reads_started  = 0;
  bit random_phase   = 1'b0;
  bit hold_off_done  = 1'b0;

  i2c_master_transaction_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  i2cms_response_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // every field random, padding left at zero
  function automatic logic [47:0] noise_fields();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    return {5'b0, b[10:0], a};
  endfunction

  // one beat, then the burst and gap pattern of the sender
  task automatic send_item(input logic [2:0] k, input logic [47:0] d);
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    if (k <= KIND_READBACK) items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap_len = 0;
        4, 5, 6, 7: gap_len = $urandom_range(1, 3);
        default:    gap_len = $urandom_range(4, 12);
      endcase
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 16);
      if (gap_len > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  task automatic send_start(input logic [2:0] k, input logic [6:0] addr, input logic [5:0] count,
                            input logic stop);
    logic [47:0] d;
    d       = noise_fields();
    d[6:0]  = addr;
    d[12:7] = count;
    d[13]   = stop;
    send_item(k, d);
  endtask

  // prescaler bits and received byte are random
  task automatic send_status(input logic [7:0] code);
    logic [47:0] d;
    d        = noise_fields();
    d[34:27] = code | 8'($urandom_range(0, 7));
    send_item(KIND_STATUS, d);
  endtask

  task automatic send_load(input logic [4:0] slot, input logic [7:0] data);
    logic [47:0] d;
    d        = noise_fields();
    d[18:14] = slot;
    d[26:19] = data;
    send_item(KIND_LOAD, d);
  endtask

  task automatic send_readback(input logic [4:0] slot);
    logic [47:0] d;
    d        = noise_fields();
    d[18:14] = slot;
    send_item(KIND_READBACK, d);
  endtask

  task automatic send_noise();
    logic [47:0] d;
    logic [2:0]  k;
    logic [7:0]  code;
    int          n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      k = 3'($urandom_range(0, 7));
      d = noise_fields();
      if (k == KIND_STATUS && $urandom_range(0, 1) == 1) begin
        // a known status code: multiples of eight up to data received with nack
        code     = 8'($urandom_range(0, 11) << 3);
        d[34:27] = code | 8'($urandom_range(0, 7));
      end
      send_item(k, d);
    end
  endtask

  task automatic run_write_transfer();
    int   count;
    int   brk;
    int   i;
    logic stop;
    case ($urandom_range(0, 19))
      18:      count = 32;
      19:      count = $urandom_range(33, 63);
      default: count = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 31) : $urandom_range(0, 4);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_load(5'($urandom_range(0, 31)), 8'($urandom));
    end
    stop = 1'($urandom_range(0, 1));
    send_start(KIND_START_WR, 7'($urandom_range(0, 127)), 6'(count), stop);
    writes_started++;
    if (count > 32) return;
    if ($urandom_range(0, 3) != 0) send_status($urandom_range(0, 1) ? ST_START : ST_REP_START);
    brk = ($urandom_range(0, 5) == 0) ? $urandom_range(0, count + 1) : -1;
    for (i = 0; i <= count; i++) begin
      if (i == brk) begin
        case ($urandom_range(0, 3))
          0:       send_status(ST_SLA_W_NACK);
          1:       send_status(ST_DATA_W_NACK);
          2:       send_status(ST_ARB_LOST);
          default: send_status(ST_BUS_ERROR);
        endcase
        return;
      end
      send_status((i == 0) ? ST_SLA_W_ACK : ST_DATA_W_ACK);
    end
  endtask

  task automatic run_read_transfer();
    int   count;
    int   extra;
    int   events;
    int   brk;
    int   i;
    logic stop;
    case ($urandom_range(0, 19))
      17, 18:  count = 32;
      19:      count = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(33, 63);
      default: count = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 31) : $urandom_range(1, 4);
    endcase
    stop = 1'($urandom_range(0, 1));
    send_start(KIND_START_RD, 7'($urandom_range(0, 127)), 6'(count), stop);
    reads_started++;
    if (count == 0 || count > 32) return;
    if ($urandom_range(0, 3) != 0) send_status($urandom_range(0, 1) ? ST_START : ST_REP_START);
    // a full buffer sometimes gets more bytes than it can hold
    extra  = (count == 32 && $urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : 0;
    events = count + 1 + extra;
    brk    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, events - 1) : -1;
    for (i = 0; i < events; i++) begin
      if (i == brk) begin
        case ($urandom_range(0, 2))
          0:       send_status(ST_SLA_R_NACK);
          1:       send_status(ST_ARB_LOST);
          default: send_status(ST_BUS_ERROR);
        endcase
        return;
      end
      if (i == 0) send_status(ST_SLA_R_ACK);
      else if (i == events - 1) send_status(ST_DATA_R_NACK);
      else send_status(ST_DATA_R_ACK);
    end
    repeat ($urandom_range(0, 2)) send_readback(5'($urandom_range(0, 31)));
  endtask

  // receiver: stretches of its own stall pattern, one long hold-off in the random part
  initial begin
    int pattern;
    int span;
    int k;
    out_tready = 1'b0;
    forever begin
      if (random_phase && !hold_off_done) begin
        repeat ($urandom_range(0, 150)) @(posedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      pattern = $urandom_range(0, 3);
      span    = $urandom_range(10, 80);
      for (k = 0; k < span; k++) begin
        case (pattern)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 2) != 0);
          2:       out_tready <= k[0];
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int i;
    int pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // buffer has no clearing pass, so write every slot before any read-back
    for (i = 0; i < 32; i++) begin
      send_load(5'(i), (i == 0) ? 8'h00 : (i == 31) ? 8'hff : 8'($urandom));
    end

    send_readback(5'd0);
    send_readback(5'd31);
    send_status(ST_BUS_ERROR);                        // bus error while idle still commands stop
    send_status(ST_START);                            // ignored while idle
    send_start(KIND_START_WR, 7'h55, 6'd33, 1'b1);    // count above the buffer depth
    send_start(KIND_START_RD, 7'h2a, 6'd0, 1'b1);     // zero-length read
    send_start(KIND_START_WR, 7'h7f, 6'd2, 1'b0);
    send_start(KIND_START_RD, 7'h00, 6'd1, 1'b1);     // rejected while busy
    send_load(5'd1, 8'h00);                           // ignored while busy
    send_status(ST_START);
    send_status(ST_SLA_W_ACK);
    send_status(ST_DATA_R_ACK);                       // wrong direction
    send_status(ST_DATA_W_ACK);
    send_status(ST_DATA_W_ACK);                       // ends without stop, arms restart
    send_start(KIND_START_RD, 7'h00, 6'd1, 1'b1);     // address driven straight away
    send_status(ST_SLA_R_ACK);
    send_status(ST_DATA_R_NACK);
    send_readback(5'd0);
    send_start(KIND_START_RD, 7'h7f, 6'd32, 1'b1);
    send_status(ST_REP_START);
    send_status(ST_SLA_R_NACK);
    send_start(KIND_START_WR, 7'h01, 6'd0, 1'b1);
    send_status(ST_ARB_LOST);
    send_start(KIND_START_WR, 7'h02, 6'd1, 1'b0);
    send_status(ST_BUS_ERROR);                        // bus error mid transfer

    random_phase = 1'b1;
    while (items_sent < ITEMS_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) run_write_transfer();
      else if (pick < 7) run_read_transfer();
      else send_noise();
    end
    in_tvalid <= 1'b0;

    // checker counts are registered, so let them settle first
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d item beats sent with %0d write and %0d read requests among them",
             items_sent, writes_started, reads_started);
    $display("%0d result beats checked, receiver hold-off of %0d cycles %s",
             checked_count, HOLD_OFF_CYCLES, hold_off_done ? "done" : "not reached");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
